[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle check on the rising clock edge, off while reset is held
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/mksr_pkg.sv]
// shared types, constants and key map of the keypad scan recorder
package mksr_pkg;

  // field widths
  localparam int OP_W    = 3;
  localparam int LEVEL_W = 12;
  localparam int INDEX_W = 4;
  localparam int CODE_W  = 8;
  localparam int LEN_W   = 4;

  // record depth default
  localparam int RECORD_DEPTH_DEF = 10;

  // wiring of the sampled levels
  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 3;

  // key map size
  localparam int MAP_ROWS = 4;
  localparam int MAP_COLS = 3;

  localparam int SCAN_ROWS = (ROW_COUNT < MAP_ROWS) ? ROW_COUNT : MAP_ROWS;
  localparam int SCAN_COLS = (COLUMN_COUNT < MAP_COLS) ? COLUMN_COUNT : MAP_COLS;

  // telephone layout, row major
  localparam logic [CODE_W-1:0] KEY_MAP [MAP_ROWS][MAP_COLS] = '{
    '{8'h31, 8'h32, 8'h33},   // 1 2 3
    '{8'h34, 8'h35, 8'h36},   // 4 5 6
    '{8'h37, 8'h38, 8'h39},   // 7 8 9
    '{8'h2A, 8'h30, 8'h23}    // * 0 #
  };

  typedef enum logic [OP_W-1:0] {
    OP_SCAN  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

endpackage

[rtl/matrix_keypad_scan_recorder_top.sv]
// keypad scan recorder: command decode, key search and key record
// path: a word is taken into the input register, then into the result register, which drives the out_ side
// throughput: one word per cycle while out_stall does not hold a waiting result, set by the single
// registered pass from the input register to the result register; a waiting result still lets one new word in
// reset (rst_n low, synchronous): record zeroed, count zero, previous key none,
// scanning off, both pipeline stages empty
module matrix_keypad_scan_recorder_top
  import mksr_pkg::*;
#(
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [LEVEL_W-1:0] in_column_levels,
  input  logic [INDEX_W-1:0] in_read_index,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CODE_W-1:0]  out_key_code,
  output logic               out_new_press,
  output logic               out_stored,
  output logic [LEN_W-1:0]   out_record_length,
  output logic [CODE_W-1:0]  out_read_data,
  output logic               out_scanning_on
);

  // count holds 0..RECORD_DEPTH
  localparam int COUNT_W   = $clog2(RECORD_DEPTH + 1);
  localparam int LEN_EXT_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

  // ---------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [LEVEL_W-1:0] s1_levels_r;
  logic [INDEX_W-1:0] s1_index_r;

  // the stage moves on when the result register is empty or being taken
  logic advance;
  assign advance  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r     <= op_t'(in_opcode);
      s1_levels_r <= in_column_levels;
      s1_index_r  <= in_read_index;
    end
  end

  // ---------------------------------------------------------------
  // block state
  // ---------------------------------------------------------------
  logic [CODE_W-1:0]  store_r [RECORD_DEPTH];
  logic [CODE_W-1:0]  store_nxt [RECORD_DEPTH];
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [CODE_W-1:0]  prev_key_r, prev_key_nxt;
  logic               scan_en_r, scan_en_nxt;

  // ---------------------------------------------------------------
  // key search: first pressed key in row-major order wins, so walk
  // backwards and let earlier positions overwrite later ones
  // ---------------------------------------------------------------
  logic [CODE_W-1:0] key_found;

  always_comb begin
    int pos;
    key_found = '0;
    for (int r = SCAN_ROWS - 1; r >= 0; r--) begin
      for (int c = SCAN_COLS - 1; c >= 0; c--) begin
        pos = r * COLUMN_COUNT + c;
        if (pos < LEVEL_W) begin
          if (!s1_levels_r[pos]) begin
            key_found = KEY_MAP[r][c];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // read port of the record
  // ---------------------------------------------------------------
  logic [CODE_W-1:0] store_rd;

  always_comb begin
    store_rd = '0;
    for (int i = 0; i < RECORD_DEPTH; i++) begin
      if (int'(s1_index_r) == i) begin
        store_rd = store_r[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // command execution
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0] count_inc;
  logic               has_room;
  logic [CODE_W-1:0]  key_res;
  logic               fresh_res;
  logic               kept_res;
  logic [CODE_W-1:0]  rdata_res;

  assign count_inc = count_r + COUNT_W'(1);
  assign has_room  = count_r < COUNT_W'(RECORD_DEPTH);

  always_comb begin
    store_nxt    = store_r;
    count_nxt    = count_r;
    prev_key_nxt = prev_key_r;
    scan_en_nxt  = scan_en_r;
    key_res      = '0;
    fresh_res    = 1'b0;
    kept_res     = 1'b0;
    rdata_res    = '0;
    unique case (s1_op_r)
      OP_SCAN: begin
        // ticks while idle are dropped
        if (scan_en_r) begin
          key_res = key_found;
          if (key_found == '0) begin
            prev_key_nxt = '0;
          end else if (key_found != prev_key_r) begin
            fresh_res    = 1'b1;
            prev_key_nxt = key_found;
            if (has_room) begin
              // append, and blank the slot after it
              for (int i = 0; i < RECORD_DEPTH; i++) begin
                if (count_r == COUNT_W'(i)) begin
                  store_nxt[i] = key_found;
                end else if (count_inc == COUNT_W'(i)) begin
                  store_nxt[i] = '0;
                end
              end
              count_nxt = count_inc;
              kept_res  = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        // only a start from idle rewinds the record
        if (!scan_en_r) begin
          count_nxt   = '0;
          scan_en_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        scan_en_nxt = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < RECORD_DEPTH; i++) begin
          store_nxt[i] = '0;
        end
        count_nxt = '0;
      end
      OP_READ: begin
        // out-of-range index falls through the read mux as zero
        rdata_res = store_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RECORD_DEPTH; i++) begin
        store_r[i] <= '0;
      end
      count_r    <= '0;
      prev_key_r <= '0;
      scan_en_r  <= 1'b0;
    end else if (advance) begin
      store_r    <= store_nxt;
      count_r    <= count_nxt;
      prev_key_r <= prev_key_nxt;
      scan_en_r  <= scan_en_nxt;
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  logic                 out_valid_r;
  logic [CODE_W-1:0]    key_code_r;
  logic                 new_press_r;
  logic                 stored_r;
  logic [LEN_W-1:0]     length_r;
  logic [CODE_W-1:0]    read_data_r;
  logic                 scanning_r;
  logic [LEN_EXT_W-1:0] length_ext;

  // reported length is the low bits of the count
  assign length_ext = LEN_EXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_code_r  <= key_res;
      new_press_r <= fresh_res;
      stored_r    <= kept_res;
      length_r    <= length_ext[LEN_W-1:0];
      read_data_r <= rdata_res;
      scanning_r  <= scan_en_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_code      = key_code_r;
  assign out_new_press     = new_press_r;
  assign out_stored        = stored_r;
  assign out_record_length = length_r;
  assign out_read_data     = read_data_r;
  assign out_scanning_on   = scanning_r;

endmodule

[rtl/mksr_checker.sv]
// port-level checks of the keypad scan recorder and their bind
`include "assert_macros.svh"

module mksr_checker
  import mksr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CODE_W-1:0]  out_key_code,
  input logic               out_new_press,
  input logic               out_stored,
  input logic [LEN_W-1:0]   out_record_length,
  input logic [CODE_W-1:0]  out_read_data,
  input logic               out_scanning_on
);

  localparam int WORD_W = 2 * CODE_W + LEN_W + 3;

  logic              press_seen;
  logic              store_seen;
  logic              held;
  logic [WORD_W-1:0] out_word;

  assign press_seen = out_valid && out_new_press;
  assign store_seen = out_valid && out_stored;
  assign held       = out_valid && out_stall;
  assign out_word   = {out_key_code, out_new_press, out_stored, out_record_length,
                       out_read_data, out_scanning_on};

  // an appended key is always a new press
  `ASSERT_CLK(a_stored_is_press, store_seen |-> out_new_press, "stored without press")

  // a new press carries a key
  `ASSERT_CLK(a_press_has_key, press_seen |-> out_key_code != '0, "press without key")

  // a new press happens only while scanning
  `ASSERT_CLK(a_press_scanning, press_seen |-> out_scanning_on, "press while idle")

  // after an append the record cannot be empty
  `ASSERT_CLK(a_stored_length, store_seen |-> out_record_length != '0, "append left empty record")

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind matrix_keypad_scan_recorder_top mksr_checker u_mksr_checker (.*);
